// ----- design/modinv_pkg.sv -----
// ----------------------------------------------------------------------------
// modinv_pkg
// Shared widths and types of the modular inverse core.
// ----------------------------------------------------------------------------
`default_nettype none

package modinv_pkg;

  // Datapath word; operand fields are one bit narrower.
  localparam int WIDTH = 64;
  localparam int FW    = WIDTH - 1;
  localparam int SH_W  = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [FW-1:0]    field_t;
  typedef logic [SH_W-1:0]  shift_t;

  // Outputs of the shared arithmetic unit.
  typedef struct packed {
    word_t diff;
    logic  ge;
    word_t sum;
  } alu_res_t;

endpackage : modinv_pkg

`default_nettype wire

// ----- design/modinv_if.sv -----
// ----------------------------------------------------------------------------
// modinv_if
// Valid/ready channels of the modular inverse core.
// ----------------------------------------------------------------------------
`default_nettype none

interface modinv_in_if import modinv_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t value;
  field_t modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface : modinv_in_if

interface modinv_out_if import modinv_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t inverse;
  logic   found;

  modport source (output valid, output inverse, output found, input ready);
  modport sink   (input valid, input inverse, input found, output ready);
endinterface : modinv_out_if

`default_nettype wire

// ----- design/modinv_alu.sv -----
// ----------------------------------------------------------------------------
// modinv_alu
// Shared subtract/compare and coefficient adder used by the align, descend and fix-up steps.
// ----------------------------------------------------------------------------
`default_nettype none

module modinv_alu import modinv_pkg::*; (
  input  word_t    x,
  input  word_t    y,
  input  word_t    p,
  input  word_t    q,
  output alu_res_t res
);

  logic [WIDTH:0] wide_diff;

  // Borrow out of the subtract doubles as the x >= y compare.
  assign wide_diff = {1'b0, x} - {1'b0, y};
  assign res.diff  = wide_diff[WIDTH-1:0];
  assign res.ge    = ~wide_diff[WIDTH];
  assign res.sum   = p + q;

endmodule : modinv_alu

`default_nettype wire

// ----- design/modular_inverse_core.sv -----
// ----------------------------------------------------------------------------
// modular_inverse_core
// Modular inverse by the extended Euclidean algorithm, one shared unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  (sink)   : one transaction carries value and modulus (63 bits each).
//   out_ch (source) : one transaction per input carries inverse and found.
//   found is set when gcd(value, modulus) is 1; inverse then lies in
//   0 .. modulus-1. Otherwise inverse is 0 and found is clear. A modulus of
//   zero gives 0 with found clear; a modulus of one gives 0 with found set.
//   The value is first reduced modulo the modulus, then Euclid runs on
//   (modulus, value mod modulus). Each division is done by shift-and-subtract
//   on one subtractor/comparator plus one coefficient adder: the divisor is
//   walked up one bit per cycle, then walked down one quotient bit per cycle.
//   Each division runs the align steps, one descend step per quotient bit,
//   then a next and a check step; load, fix-up and output steps close the
//   item (fewer fix-up steps when no inverse exists, none for a zero
//   modulus). The worst case, consecutive Fibonacci numbers near the top
//   of the range, runs about 90 divisions.
//   One item is in flight: in_ch.ready is high only when the core is idle.
//   The result is held in the output register until out_ch.ready is seen;
//   a stalled receiver simply holds the core in its output state.
//   rst_n (synchronous, active low) drops any transaction in progress.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse_core import modinv_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  modinv_in_if.sink      in_ch,
  modinv_out_if.source   out_ch
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ALIGN = 3'd1;
  localparam logic [2:0] ST_DESC  = 3'd2;
  localparam logic [2:0] ST_NEXT  = 3'd3;
  localparam logic [2:0] ST_CHECK = 3'd4;
  localparam logic [2:0] ST_FIX1  = 3'd5;
  localparam logic [2:0] ST_FIX2  = 3'd6;
  localparam logic [2:0] ST_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;

  // a/ua: remainder r0 and its coefficient; b/ub: r1 and its coefficient.
  // bs/ubs: divisor and coefficient shifted by sh during one division.
  word_t  a_r, a_nxt;
  word_t  b_r, b_nxt;
  word_t  bs_r, bs_nxt;
  word_t  ua_r, ua_nxt;
  word_t  ub_r, ub_nxt;
  word_t  ubs_r, ubs_nxt;
  word_t  m_r, m_nxt;
  word_t  res_r, res_nxt;
  shift_t sh_r, sh_nxt;
  logic   neg0_r, neg0_nxt;
  logic   neg1_r, neg1_nxt;
  logic   red_r, red_nxt;     // set while reducing value mod modulus
  logic   found_r, found_nxt;

  word_t    alu_x, alu_y;
  alu_res_t alu;

  modinv_alu u_alu (
    .x   (alu_x),
    .y   (alu_y),
    .p   (ua_r),
    .q   (ubs_r),
    .res (alu)
  );

  // Steer the shared subtractor by step.
  always_comb begin
    unique case (state_r)
      ST_ALIGN: begin
        alu_x = a_r;
        alu_y = {bs_r[WIDTH-2:0], 1'b0};
      end
      ST_FIX1: begin
        alu_x = m_r;
        alu_y = ua_r;
      end
      ST_FIX2: begin
        alu_x = res_r;
        alu_y = m_r;
      end
      default: begin
        alu_x = a_r;
        alu_y = bs_r;
      end
    endcase
  end

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = (state_r == ST_OUT);
  assign out_ch.inverse = res_r[FW-1:0];
  assign out_ch.found   = found_r;

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    bs_nxt    = bs_r;
    ua_nxt    = ua_r;
    ub_nxt    = ub_r;
    ubs_nxt   = ubs_r;
    m_nxt     = m_r;
    res_nxt   = res_r;
    sh_nxt    = sh_r;
    neg0_nxt  = neg0_r;
    neg1_nxt  = neg1_r;
    red_nxt   = red_r;
    found_nxt = found_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          m_nxt   = {1'b0, in_ch.modulus};
          a_nxt   = {1'b0, in_ch.value};
          b_nxt   = {1'b0, in_ch.modulus};
          bs_nxt  = {1'b0, in_ch.modulus};
          ua_nxt  = '0;
          ub_nxt  = '0;
          ubs_nxt = '0;
          sh_nxt  = '0;
          red_nxt = 1'b1;
          if (in_ch.modulus == '0) begin
            res_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_ALIGN;
          end
        end
      end
      ST_ALIGN: begin
        // Advance the divisor while twice it still fits under the remainder.
        if (alu.ge) begin
          bs_nxt  = {bs_r[WIDTH-2:0], 1'b0};
          ubs_nxt = {ubs_r[WIDTH-2:0], 1'b0};
          sh_nxt  = sh_r + shift_t'(1);
        end else begin
          state_nxt = ST_DESC;
        end
      end
      ST_DESC: begin
        // One quotient bit: subtract the shifted divisor from the remainder, add the coefficient outside the reduction.
        if (alu.ge) begin
          a_nxt = alu.diff;
          if (!red_r) begin
            ua_nxt = alu.sum;
          end
        end
        if (sh_r == '0) begin
          state_nxt = ST_NEXT;
        end else begin
          bs_nxt  = {1'b0, bs_r[WIDTH-1:1]};
          ubs_nxt = {1'b0, ubs_r[WIDTH-1:1]};
          sh_nxt  = sh_r - shift_t'(1);
        end
      end
      ST_NEXT: begin
        if (red_r) begin
          // Start Euclid on (modulus, value mod modulus).
          a_nxt    = m_r;
          b_nxt    = a_r;
          ua_nxt   = '0;
          ub_nxt   = word_t'(1);
          neg0_nxt = 1'b0;
          neg1_nxt = 1'b0;
          red_nxt  = 1'b0;
        end else begin
          a_nxt    = b_r;
          b_nxt    = a_r;
          ua_nxt   = ub_r;
          ub_nxt   = ua_r;
          neg0_nxt = neg1_r;
          neg1_nxt = ~neg1_r;
        end
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (b_r == '0) begin
          state_nxt = ST_FIX1;
        end else begin
          bs_nxt    = b_r;
          ubs_nxt   = ub_r;
          sh_nxt    = '0;
          state_nxt = ST_ALIGN;
        end
      end
      ST_FIX1: begin
        if (a_r == word_t'(1)) begin
          found_nxt = 1'b1;
          res_nxt   = (neg0_r && (ua_r != '0)) ? alu.diff : ua_r;
          state_nxt = ST_FIX2;
        end else begin
          found_nxt = 1'b0;
          res_nxt   = '0;
          state_nxt = ST_OUT;
        end
      end
      ST_FIX2: begin
        // Fold a coefficient equal to the modulus back into range.
        if (alu.ge) begin
          res_nxt = alu.diff;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    bs_r    <= bs_nxt;
    ua_r    <= ua_nxt;
    ub_r    <= ub_nxt;
    ubs_r   <= ubs_nxt;
    m_r     <= m_nxt;
    res_r   <= res_nxt;
    sh_r    <= sh_nxt;
    neg0_r  <= neg0_nxt;
    neg1_r  <= neg1_nxt;
    red_r   <= red_nxt;
    found_r <= found_nxt;
  end

  // Remainder never leaves the operand range during the align and descend steps.
  a_range_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ALIGN || state_r == ST_DESC) |-> !a_r[WIDTH-1])
    else $error("remainder left the operand range");

  // The divisor shift never walks past the operand width.
  sh_range_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ALIGN || state_r == ST_DESC) |-> (sh_r < SH_W'(FW)))
    else $error("divisor shift out of range");

  // The final coefficient magnitude is bounded by the modulus.
  coef_bound_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIX1) |-> (ua_r <= m_r))
    else $error("coefficient magnitude exceeds modulus");

  // A found inverse is reduced below the modulus.
  inv_range_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && found_r) |-> (res_r < m_r))
    else $error("inverse not reduced");

  // One result per transaction: the output drops after it is taken.
  out_once_chk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready) |=> (!out_ch.valid && in_ch.ready))
    else $error("result repeated after handoff");

endmodule : modular_inverse_core

`default_nettype wire
